// ===== rtl/grg_pkg.sv =====
`timescale 1ns / 1ps
package grg_pkg;

  // single-precision encodings
  localparam logic [30:0] INF_MAG  = 31'h7F800000;
  localparam logic [31:0] QNAN     = 32'h7FC00000;
  localparam logic [31:0] ONE      = 32'h3F800000;

  // pipeline shape
  localparam int SQRT_STEPS = 28;
  localparam int DIV_STEPS  = 27;
  localparam int HYP_LAT    = 4 + SQRT_STEPS + 2;
  localparam int DIV_LAT    = 1 + DIV_STEPS + 2;
  localparam int PIPE_DEPTH = HYP_LAT + 1 + 2 * DIV_LAT;

  typedef logic signed [11:0] exp_t;

  // finite nonzero magnitude as mant * 2^ex, mant[23] set
  typedef struct packed {
    logic [23:0] mant;
    exp_t        ex;
  } unpacked_t;

  // first half of rounding, registered between the two halves
  typedef struct packed {
    logic        zero;
    logic [23:0] kept;
    logic        rnd;
    exp_t        bexp;
  } round_t;

  function automatic unpacked_t decode(logic [30:0] m);
    unpacked_t u;
    logic [4:0] lz;
    lz = '0;
    if (m[30:23] == 8'd0) begin
      for (int i = 0; i < 23; i++) begin
        if (m[i]) lz = 5'(23 - i);
      end
      u.mant = {1'b0, m[22:0]} << lz;
      u.ex   = -12'sd149 - $signed({7'b0, lz});
    end else begin
      u.mant = {1'b1, m[22:0]};
      u.ex   = $signed({4'b0, m[30:23]}) - 12'sd150;
    end
    return u;
  endfunction

  // pick the kept bits and the round-up decision (nearest even)
  function automatic round_t pack_round(logic [27:0] m, exp_t e, logic sticky);
    round_t      p;
    logic [4:0]  len;
    exp_t        sh;
    exp_t        sub;
    logic [5:0]  sa;
    logic [39:0] ext;
    logic [39:0] low_mask;
    logic [27:0] kept;
    len = '0;
    for (int i = 0; i < 28; i++) begin
      if (m[i]) len = 5'(i + 1);
    end
    sh  = $signed({7'b0, len}) - 12'sd24;
    sub = -12'sd149 - e;
    if (sub > sh) sh = sub;
    if (sh >= 12'sd40) sa = 6'd39;
    else if (sh < 12'sd1) sa = 6'd1;
    else sa = sh[5:0];
    ext      = {12'b0, m};
    kept     = m >> sa;
    low_mask = (40'd1 << (sa - 6'd1)) - 40'd1;
    p.zero   = (sh >= 12'sd40);
    p.kept   = kept[23:0];
    p.rnd    = ext[sa - 6'd1] & ((|(ext & low_mask)) | sticky | kept[0]);
    p.bexp   = e + $signed({6'b0, sa}) + 12'sd150;
    return p;
  endfunction

  // assemble the magnitude; overflow saturates to infinity
  function automatic logic [30:0] pack_final(round_t p);
    logic signed [36:0] bits;
    bits = (37'(p.bexp) - 37'sd1) <<< 23;
    bits = bits + $signed({13'b0, p.kept}) + $signed({36'b0, p.rnd});
    if (p.zero) return '0;
    else if (bits >= 37'sd2139095040) return INF_MAG;
    else return bits[30:0];
  endfunction

endpackage

// ===== rtl/grg_hypot.sv =====
`timescale 1ns / 1ps
module grg_hypot import grg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [30:0] ma_i,
  input  logic [30:0] mb_i,
  output logic        valid_o,
  output logic [30:0] mag_o
);

  typedef struct packed {
    logic [55:0] rad;
    logic [29:0] rem;
    logic [27:0] res;
    logic        st;
    exp_t        ex;
    logic        inf;
    logic        nan;
  } sq_t;

  // stage 1: order and unpack
  logic [30:0] hi, lo;
  unpacked_t   uh, ul;
  logic        v1_q, inf1_q, nan1_q;
  logic [23:0] mx1_q, my1_q;
  exp_t        ex1_q, d1_q;

  always_comb begin
    hi = (ma_i >= mb_i) ? ma_i : mb_i;
    lo = (ma_i >= mb_i) ? mb_i : ma_i;
    uh = decode(hi);
    ul = decode(lo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inf1_q <= (ma_i == INF_MAG) || (mb_i == INF_MAG);
      nan1_q <= (ma_i > INF_MAG) || (mb_i > INF_MAG);
      mx1_q  <= uh.mant;
      my1_q  <= ul.mant;
      ex1_q  <= uh.ex;
      d1_q   <= uh.ex - ul.ex;
    end
  end

  // stage 2: squares
  logic        v2_q, inf2_q, nan2_q;
  logic [53:0] sx2_q, sy2_q;
  exp_t        ex2_q, d2_q;
  logic [47:0] sqx, sqy;

  assign sqx = {24'b0, mx1_q} * {24'b0, mx1_q};
  assign sqy = {24'b0, my1_q} * {24'b0, my1_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inf2_q <= inf1_q;
      nan2_q <= nan1_q;
      sx2_q  <= {sqx, 6'b0};
      sy2_q  <= {sqy, 6'b0};
      ex2_q  <= ex1_q;
      d2_q   <= d1_q;
    end
  end

  // stage 3: align the smaller square
  logic        v3_q, inf3_q, nan3_q, st3_q;
  logic [53:0] sx3_q, sy3_q;
  exp_t        ex3_q;
  logic [5:0]  k2;
  logic [53:0] al_mask, sy_al;
  logic        st_al;

  always_comb begin
    k2      = {d2_q[4:0], 1'b0};
    al_mask = (54'd1 << k2) - 54'd1;
    if (d2_q >= 12'sd32) begin
      st_al = 1'b1;
      sy_al = '0;
    end else if (d2_q > 12'sd0) begin
      st_al = |(sy2_q & al_mask);
      sy_al = sy2_q >> k2;
    end else begin
      st_al = 1'b0;
      sy_al = sy2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inf3_q <= inf2_q;
      nan3_q <= nan2_q;
      st3_q  <= st_al;
      sx3_q  <= sx2_q;
      sy3_q  <= sy_al;
      ex3_q  <= ex2_q;
    end
  end

  // stage 4 is the root's first register: sum of squares
  sq_t  sq_q [SQRT_STEPS + 1];
  logic sv_q [SQRT_STEPS + 1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q[0].rad <= {2'b0, sx3_q} + {2'b0, sy3_q};
      sq_q[0].rem <= '0;
      sq_q[0].res <= '0;
      sq_q[0].st  <= st3_q;
      sq_q[0].ex  <= ex3_q;
      sq_q[0].inf <= inf3_q;
      sq_q[0].nan <= nan3_q;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [31:0] cur, trial;
    sq_t         nxt;

    always_comb begin
      nxt   = sq_q[k];
      cur   = {sq_q[k].rem, sq_q[k].rad[55:54]};
      trial = {2'b0, sq_q[k].res, 2'b01};
      if (cur >= trial) begin
        nxt.rem = 30'(cur - trial);
        nxt.res = {sq_q[k].res[26:0], 1'b1};
      end else begin
        nxt.rem = cur[29:0];
        nxt.res = {sq_q[k].res[26:0], 1'b0};
      end
      nxt.rad = {sq_q[k].rad[53:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k + 1] <= 1'b0;
      end else if (en_i) begin
        sv_q[k + 1] <= sv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[k + 1] <= nxt;
      end
    end
  end

  // rounding, then specials
  round_t pa_q;
  logic   pv_q, pinf_q, pnan_q, ov_q;
  logic [30:0] mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= sv_q[SQRT_STEPS];
      ov_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q   <= pack_round(sq_q[SQRT_STEPS].res, sq_q[SQRT_STEPS].ex - 12'sd3,
                           sq_q[SQRT_STEPS].st | (|sq_q[SQRT_STEPS].rem));
      pinf_q <= sq_q[SQRT_STEPS].inf;
      pnan_q <= sq_q[SQRT_STEPS].nan;
      if (pinf_q) mag_q <= INF_MAG;
      else if (pnan_q) mag_q <= QNAN[30:0];
      else mag_q <= pack_final(pa_q);
    end
  end

  assign valid_o = ov_q;
  assign mag_o   = mag_q;

endmodule

// ===== rtl/grg_fdiv.sv =====
`timescale 1ns / 1ps
module grg_fdiv import grg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic        valid_o,
  output logic [31:0] q_o
);

  typedef enum logic [1:0] {SP_NONE, SP_NAN, SP_INF, SP_ZERO} special_e;

  typedef struct packed {
    logic [24:0] rem;
    logic [26:0] quo;
    logic [23:0] my;
    exp_t        ex;
    logic        sign;
    special_e    sp;
  } dstep_t;

  // stage 1: classify and unpack
  unpacked_t ux, uy;
  logic      x_nan, y_nan, x_inf, y_inf, x_zero, y_zero;
  special_e  sp;

  always_comb begin
    ux     = decode(x_i[30:0]);
    uy     = decode(y_i[30:0]);
    x_nan  = x_i[30:0] > INF_MAG;
    y_nan  = y_i[30:0] > INF_MAG;
    x_inf  = x_i[30:0] == INF_MAG;
    y_inf  = y_i[30:0] == INF_MAG;
    x_zero = x_i[30:0] == '0;
    y_zero = y_i[30:0] == '0;
    if (x_nan || y_nan || (x_inf && y_inf) || (x_zero && y_zero)) sp = SP_NAN;
    else if (x_inf || y_zero) sp = SP_INF;
    else if (x_zero || y_inf) sp = SP_ZERO;
    else sp = SP_NONE;
  end

  dstep_t ds_q [DIV_STEPS + 1];
  logic   dv_q [DIV_STEPS + 1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q[0].rem  <= {1'b0, ux.mant};
      ds_q[0].quo  <= '0;
      ds_q[0].my   <= uy.mant;
      ds_q[0].ex   <= ux.ex - uy.ex - 12'sd26;
      ds_q[0].sign <= x_i[31] ^ y_i[31];
      ds_q[0].sp   <= sp;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [24:0] cur;
    dstep_t      nxt;

    always_comb begin
      nxt = ds_q[j];
      if (j == 0) cur = ds_q[j].rem;
      else cur = {ds_q[j].rem[23:0], 1'b0};
      if (cur >= {1'b0, ds_q[j].my}) begin
        nxt.rem = cur - {1'b0, ds_q[j].my};
        nxt.quo = {ds_q[j].quo[25:0], 1'b1};
      end else begin
        nxt.rem = cur;
        nxt.quo = {ds_q[j].quo[25:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j + 1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j + 1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ds_q[j + 1] <= nxt;
      end
    end
  end

  // rounding, then specials
  round_t      pa_q;
  logic        pv_q, psign_q, ov_q;
  special_e    psp_q;
  logic [31:0] q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= dv_q[DIV_STEPS];
      ov_q <= pv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q    <= pack_round({1'b0, ds_q[DIV_STEPS].quo}, ds_q[DIV_STEPS].ex,
                            |ds_q[DIV_STEPS].rem);
      psign_q <= ds_q[DIV_STEPS].sign;
      psp_q   <= ds_q[DIV_STEPS].sp;
      case (psp_q)
        SP_NAN:  q_q <= QNAN;
        SP_INF:  q_q <= {psign_q, INF_MAG};
        SP_ZERO: q_q <= {psign_q, 31'b0};
        default: q_q <= {psign_q, pack_final(pa_q)};
      endcase
    end
  end

  assign valid_o = ov_q;
  assign q_o     = q_q;

endmodule

// ===== rtl/givens_rotation_generator_core.sv =====
`timescale 1ns / 1ps
// Givens rotation generator (BLAS rotg, single precision). Each accepted
// pair (a, b) yields r, z, c and s, correctly rounded to nearest even, with
// exact subnormal handling and NaNs from arithmetic returned as 0x7FC00000.
// The block takes one pair per clock while in_ready_o is high. The
// pipeline is the exact hypot unit (square root, one root bit per stage),
// then the a/r and b/r dividers side by side, then the 1/c divider, each
// divider resolving one quotient bit per stage. A two-word
// output buffer lets input keep flowing while a result waits to be taken;
// a stall on the output side freezes the whole pipeline without loss.
module givens_rotation_generator_core import grg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] a_value_i,
  input  logic [31:0] b_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] r_value_o,
  output logic [31:0] z_value_o,
  output logic [31:0] cosine_o,
  output logic [31:0] sine_o
);

  typedef enum logic [1:0] {KIND_BZERO, KIND_AZERO, KIND_GEN} kind_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    kind_e       kind;
    logic        a_big;
  } side1_t;

  typedef struct packed {
    logic [31:0] r;
    kind_e       kind;
    logic        a_big;
  } side2_t;

  typedef struct packed {
    logic [31:0] r;
    kind_e       kind;
    logic        a_big;
    logic [31:0] c;
    logic [31:0] s;
  } side3_t;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] z;
    logic [31:0] c;
    logic [31:0] s;
  } word_t;

  logic en;
  logic [1:0] cnt_q;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  // input classification
  side1_t side_in;
  logic   in_nan;

  always_comb begin
    in_nan        = (a_value_i[30:0] > INF_MAG) || (b_value_i[30:0] > INF_MAG);
    side_in.a     = a_value_i;
    side_in.b     = b_value_i;
    side_in.a_big = !in_nan && (a_value_i[30:0] > b_value_i[30:0]);
    if (b_value_i[30:0] == '0) side_in.kind = KIND_BZERO;
    else if (a_value_i[30:0] == '0) side_in.kind = KIND_AZERO;
    else side_in.kind = KIND_GEN;
  end

  // hypot unit with its side line
  logic        h_valid;
  logic [30:0] h_mag;
  side1_t      s1_q [HYP_LAT];

  grg_hypot u_hypot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .ma_i    (a_value_i[30:0]),
    .mb_i    (b_value_i[30:0]),
    .valid_o (h_valid),
    .mag_o   (h_mag)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q[0] <= side_in;
      for (int i = 1; i < HYP_LAT; i++) s1_q[i] <= s1_q[i - 1];
    end
  end

  // signed norm
  side1_t h_side;
  logic   r_sign;
  logic [31:0] r_sel;
  logic   rv_q;
  logic [31:0] ra_q, rb_q;
  side2_t rs_q;

  always_comb begin
    h_side = s1_q[HYP_LAT - 1];
    r_sign = h_side.a_big ? h_side.a[31] : h_side.b[31];
    case (h_side.kind)
      KIND_BZERO: r_sel = h_side.a;
      KIND_AZERO: r_sel = h_side.b;
      default:    r_sel = (h_mag > INF_MAG) ? QNAN : {r_sign, h_mag};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= h_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra_q        <= h_side.a;
      rb_q        <= h_side.b;
      rs_q.r      <= r_sel;
      rs_q.kind   <= h_side.kind;
      rs_q.a_big  <= h_side.a_big;
    end
  end

  // c = a / r and s = b / r
  logic        c_valid, s_valid;
  logic [31:0] c_val, s_val;
  side2_t      s2_q [DIV_LAT];

  grg_fdiv u_div_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv_q),
    .x_i     (ra_q),
    .y_i     (rs_q.r),
    .valid_o (c_valid),
    .q_o     (c_val)
  );

  grg_fdiv u_div_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv_q),
    .x_i     (rb_q),
    .y_i     (rs_q.r),
    .valid_o (s_valid),
    .q_o     (s_val)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q[0] <= rs_q;
      for (int i = 1; i < DIV_LAT; i++) s2_q[i] <= s2_q[i - 1];
    end
  end

  // 1 / c
  logic        z_valid;
  logic [31:0] z_div;
  side3_t      s3_in;
  side3_t      s3_q [DIV_LAT];

  grg_fdiv u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid && s_valid),
    .x_i     (ONE),
    .y_i     (c_val),
    .valid_o (z_valid),
    .q_o     (z_div)
  );

  always_comb begin
    s3_in.r     = s2_q[DIV_LAT - 1].r;
    s3_in.kind  = s2_q[DIV_LAT - 1].kind;
    s3_in.a_big = s2_q[DIV_LAT - 1].a_big;
    s3_in.c     = c_val;
    s3_in.s     = s_val;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q[0] <= s3_in;
      for (int i = 1; i < DIV_LAT; i++) s3_q[i] <= s3_q[i - 1];
    end
  end

  // final selection
  side3_t f_side;
  word_t  res;

  always_comb begin
    f_side = s3_q[DIV_LAT - 1];
    res.r  = f_side.r;
    case (f_side.kind)
      KIND_BZERO: begin
        res.z = '0;
        res.c = ONE;
        res.s = '0;
      end
      KIND_AZERO: begin
        res.z = ONE;
        res.c = '0;
        res.s = ONE;
      end
      default: begin
        res.c = f_side.c;
        res.s = f_side.s;
        if (f_side.a_big) res.z = f_side.s;
        else if (f_side.c[30:0] != '0) res.z = z_div;
        else res.z = ONE;
      end
    endcase
  end

  // two-word output buffer
  word_t ob_q [2];
  logic  wp_q, rp_q;
  logic  push, pop;

  assign push = en && z_valid;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ob_q[wp_q] <= res;
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign r_value_o   = ob_q[rp_q].r;
  assign z_value_o   = ob_q[rp_q].z;
  assign cosine_o    = ob_q[rp_q].c;
  assign sine_o      = ob_q[rp_q].s;

endmodule

// ===== rtl/grg_checker.sv =====
`timescale 1ns / 1ps
module grg_checker import grg_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [31:0] a_value_i,
  input logic [31:0] b_value_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] r_value_o,
  input logic [31:0] z_value_o,
  input logic [31:0] cosine_o,
  input logic [31:0] sine_o
);

  // words in flight, seen from the ports
  logic [7:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {7'b0, in_acc} - {7'b0, out_acc};
    end
  end

  // a held result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(r_value_o) &&
      $stable(z_value_o) && $stable(cosine_o) && $stable(sine_o))
    else $error("held result changed");

  // no result without an earlier pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> inflight_q != 8'd0)
    else $error("result without input");

  // pipeline plus buffer bounds the words in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 8'(PIPE_DEPTH + 2))
    else $error("too many words in flight");

  // input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind givens_rotation_generator_core grg_checker u_grg_checker (.*);
